[design/top_k_score_tracker_core_defines.svh]
// Assertion macros for the top-k score tracker.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef TOP_K_SCORE_TRACKER_CORE_DEFINES_SVH
`define TOP_K_SCORE_TRACKER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define TKST_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("tkst check failed");
`define TKST_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("tkst check failed");
`else
`define TKST_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define TKST_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

[design/tkst_pkg.sv]
// Shared types and constants for the top-k score tracker.
// No dependencies; imported by the cell and the top level.
`timescale 1ns / 1ps

package tkst_pkg;

    localparam int TKST_MAX_ENTRIES = 64;
    localparam int KIND_W  = 2;
    localparam int ID_W    = 32;
    localparam int SCORE_W = 32;
    localparam int RANK_W  = 6;
    localparam int KEPT_W  = 7;
    localparam int COUNT_W = 32;
    localparam int LIMIT_W = 7;

    localparam logic [KIND_W-1:0] KIND_OFFER = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;
    localparam logic [KIND_W-1:0] KIND_IDLE  = 2'd3;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

    typedef struct packed {
        logic [KIND_W-1:0]         kind;
        logic [ID_W-1:0]           user_id;
        logic signed [SCORE_W-1:0] score_value;
        logic [RANK_W-1:0]         rank;
    } in_req_t;

    typedef struct packed {
        logic                      accepted;
        logic                      entry_valid;
        logic [ID_W-1:0]           entry_user;
        logic signed [SCORE_W-1:0] entry_score;
        logic [KEPT_W-1:0]         kept_entries;
        logic [COUNT_W-1:0]        offers_seen;
    } out_rsp_t;

    typedef struct packed {
        logic [ID_W-1:0]           user;
        logic signed [SCORE_W-1:0] score;
    } entry_t;

    typedef struct packed {
        logic insert;
        logic in_range;
        logic at_last;
    } cell_ctl_t;

endpackage

[design/tkst_cell.sv]
// One rank slot of the sorted insert row: holds a pair, compares it with the offer.
// Depends on tkst_pkg.
`timescale 1ns / 1ps

module tkst_cell import tkst_pkg::*; (
    input  logic      aclk,
    input  cell_ctl_t ctl,
    input  entry_t    new_entry,
    input  entry_t    left_entry,
    input  logic      left_ge,
    output entry_t    entry_q,
    output logic      ge
);

    entry_t entry_reg;
    logic   take_new;

    assign ge       = entry_reg.score >= new_entry.score;
    assign take_new = ctl.at_last ? left_ge : (left_ge && !ge);
    assign entry_q  = entry_reg;

    always_ff @(posedge aclk) begin
        if (ctl.insert && ctl.in_range) begin
            if (take_new) begin
                entry_reg <= new_entry;
            end else if (!left_ge) begin
                entry_reg <= left_entry;
            end
        end
    end

endmodule

[design/top_k_score_tracker_core.sv]
// Top-k score tracker: keeps the K best (user, score) pairs in descending score order,
// earlier arrivals first among equal scores, in a row of MAX_ENTRIES compare-and-shift
// cells that all act in the same cycle. Every request (offer, read, clear, idle) yields
// one response; a new request is taken each cycle while the response register is free
// or being drained. K comes from the limit written on cfg_wdata with cfg_we, with 0
// acting as 1 and values above MAX_ENTRIES acting as MAX_ENTRIES; lowering it drops
// the lowest entries at once. Depends on tkst_pkg and the defines header.
`timescale 1ns / 1ps
`include "top_k_score_tracker_core_defines.svh"

module top_k_score_tracker_core import tkst_pkg::*; #(
    parameter int MAX_ENTRIES = TKST_MAX_ENTRIES
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  in_req_t            s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output out_rsp_t           m_data,
    input  logic               cfg_we,
    input  logic [LIMIT_W-1:0] cfg_wdata
);

    localparam int CW   = $clog2(MAX_ENTRIES + 1);
    localparam int IW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int RW   = (IW > RANK_W) ? IW : RANK_W;
    localparam int CMPW = (RW > CW) ? RW : CW;

    function automatic logic [CW-1:0] clamp_limit(input logic [LIMIT_W-1:0] v);
        logic [CW-1:0] r;
        if (v == '0) begin
            r = CW'(1);
        end else if (int'(v) > MAX_ENTRIES) begin
            r = CW'(MAX_ENTRIES);
        end else begin
            r = CW'(v);
        end
        return r;
    endfunction

    logic [LIMIT_W-1:0] limit_reg;
    logic [CW-1:0]      kept_total_reg, kept_total_next;
    logic [COUNT_W-1:0] offer_total_reg, offer_total_next;
    logic               out_valid_reg;
    out_rsp_t           out_data_reg, out_data_next;

    entry_t                 cell_q [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] cell_ge;
    cell_ctl_t              cell_ctl [MAX_ENTRIES];
    entry_t                 new_entry;

    logic [CW-1:0]   eff_limit, eff_m1, last_pos, cfg_limit;
    logic [IW-1:0]   limit_idx, rd_idx;
    logic [RW-1:0]   rank_w;
    logic            full, offer_ok, in_acc, offer_ins, rd_hit;
    entry_t          rd_entry;

    assign eff_limit = clamp_limit(limit_reg);
    assign cfg_limit = clamp_limit(cfg_wdata);
    assign eff_m1    = eff_limit - 1'b1;
    assign limit_idx = eff_m1[IW-1:0];
    assign full      = kept_total_reg >= eff_limit;
    assign last_pos  = full ? eff_m1 : kept_total_reg;
    assign offer_ok  = !full || !cell_ge[limit_idx];

    assign s_ready   = !out_valid_reg || m_ready;
    assign in_acc    = s_valid && s_ready;
    assign offer_ins = in_acc && (s_data.kind == KIND_OFFER) && offer_ok;

    assign new_entry.user  = s_data.user_id;
    assign new_entry.score = s_data.score_value;

    assign rank_w   = RW'(s_data.rank);
    assign rd_idx   = rank_w[IW-1:0];
    assign rd_hit   = CMPW'(s_data.rank) < CMPW'(kept_total_reg);
    assign rd_entry = cell_q[rd_idx];

    for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
        assign cell_ctl[i].insert   = offer_ins;
        assign cell_ctl[i].in_range = CW'(i) <= last_pos;
        assign cell_ctl[i].at_last  = CW'(i) == last_pos;
        if (i == 0) begin : g_head
            tkst_cell u_cell (
                .aclk       (aclk),
                .ctl        (cell_ctl[i]),
                .new_entry  (new_entry),
                .left_entry (new_entry),
                .left_ge    (1'b1),
                .entry_q    (cell_q[i]),
                .ge         (cell_ge[i])
            );
        end else begin : g_body
            tkst_cell u_cell (
                .aclk       (aclk),
                .ctl        (cell_ctl[i]),
                .new_entry  (new_entry),
                .left_entry (cell_q[i-1]),
                .left_ge    (cell_ge[i-1]),
                .entry_q    (cell_q[i]),
                .ge         (cell_ge[i])
            );
        end
    end

    always_comb begin
        kept_total_next  = kept_total_reg;
        offer_total_next = offer_total_reg;
        out_data_next    = '0;
        if (cfg_we && (kept_total_reg > cfg_limit)) begin
            kept_total_next = cfg_limit;
        end
        if (in_acc) begin
            unique case (s_data.kind)
                KIND_OFFER: begin
                    if (offer_total_reg != '1) begin
                        offer_total_next = offer_total_reg + 1'b1;
                    end
                    if (!full) begin
                        kept_total_next = kept_total_reg + 1'b1;
                    end
                    out_data_next.accepted = offer_ok;
                end
                KIND_READ: begin
                    if (rd_hit) begin
                        out_data_next.entry_valid = 1'b1;
                        out_data_next.entry_user  = rd_entry.user;
                        out_data_next.entry_score = rd_entry.score;
                    end
                end
                KIND_CLEAR: begin
                    kept_total_next  = '0;
                    offer_total_next = '0;
                end
                KIND_IDLE: begin
                end
            endcase
        end
        out_data_next.kept_entries = KEPT_W'(kept_total_next);
        out_data_next.offers_seen  = offer_total_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg       <= LIMIT_RESET;
            kept_total_reg  <= '0;
            offer_total_reg <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                limit_reg <= cfg_wdata;
            end
            kept_total_reg  <= kept_total_next;
            offer_total_reg <= offer_total_next;
            if (in_acc) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    `TKST_ASSERT_NOW(a_total_bounded, aclk, aresetn, 1'b1, kept_total_reg <= eff_limit)
    `TKST_ASSERT_NEXT(a_offer_grows, aclk, aresetn, offer_ins && !full && !cfg_we, kept_total_reg == $past(kept_total_reg) + 1'b1)
    `TKST_ASSERT_NEXT(a_clear_zeroes, aclk, aresetn, in_acc && (s_data.kind == KIND_CLEAR), m_valid && (m_data.offers_seen == '0) && (m_data.kept_entries == '0))

endmodule

[tb/tb.sv]
// Self-checking testbench for top_k_score_tracker_core: a ranking scoreboard predicts
// every response, while plain tasks drive requests, limit writes and random backpressure.
// Depends on tkst_pkg and the top_k_score_tracker_core RTL.
`timescale 1ns / 1ps

import tkst_pkg::*;

class rank_table_board;
    logic [ID_W-1:0]           tab_user[TKST_MAX_ENTRIES];
    logic signed [SCORE_W-1:0] tab_score[TKST_MAX_ENTRIES];
    logic [KEPT_W-1:0]         tab_count;
    logic [COUNT_W-1:0]        offer_count;
    logic [LIMIT_W-1:0]        limit_reg;
    out_rsp_t                  due_rsp[$];
    int mismatches;
    int n_req;
    int n_rsp;
    int n_taken;
    int n_refused;
    int n_limits;

    function new();
        tab_count   = '0;
        offer_count = '0;
        limit_reg   = LIMIT_RESET;
        mismatches  = 0;
        n_req       = 0;
        n_rsp       = 0;
        n_taken     = 0;
        n_refused   = 0;
        n_limits    = 0;
    endfunction

    function int eff_k();
        if (limit_reg == 0)
            return 1;
        if (limit_reg > TKST_MAX_ENTRIES)
            return TKST_MAX_ENTRIES;
        return limit_reg;
    endfunction

    function void set_limit(input logic [LIMIT_W-1:0] v);
        limit_reg = v;
        n_limits++;
        // drop the lowest entries when K shrinks
        if (tab_count > eff_k())
            tab_count = eff_k();
    endfunction

    function bit place_offer(input logic [ID_W-1:0] user,
                             input logic signed [SCORE_W-1:0] score);
        int k;
        int last;
        int pos;
        k = eff_k();
        if (offer_count != '1)
            offer_count++;
        if (tab_count >= k) begin
            if (!(score > tab_score[k-1])) begin
                n_refused++;
                return 1'b0;
            end
            last = k - 1;
        end else begin
            last = tab_count;
            tab_count++;
        end
        pos = 0;
        while (pos < last && tab_score[pos] >= score)
            pos++;
        for (int i = last; i > pos; i--) begin
            tab_user[i]  = tab_user[i-1];
            tab_score[i] = tab_score[i-1];
        end
        tab_user[pos]  = user;
        tab_score[pos] = score;
        n_taken++;
        return 1'b1;
    endfunction

    function void note_request(input in_req_t r);
        out_rsp_t e;
        e = '0;
        case (r.kind)
            KIND_OFFER: begin
                e.accepted = place_offer(r.user_id, r.score_value);
            end
            KIND_READ: begin
                if (r.rank < tab_count) begin
                    e.entry_valid = 1'b1;
                    e.entry_user  = tab_user[r.rank];
                    e.entry_score = tab_score[r.rank];
                end
            end
            KIND_CLEAR: begin
                tab_count   = '0;
                offer_count = '0;
            end
            default: begin
            end
        endcase
        e.kept_entries = tab_count;
        e.offers_seen  = offer_count;
        due_rsp = {due_rsp, e};
        n_req++;
    endfunction

    function void check_response(input out_rsp_t got);
        out_rsp_t e;
        n_rsp++;
        if (due_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("response %0d with no request pending: acc=%0b vld=%0b user=%h score=%0d kept=%0d offers=%0d",
                         n_rsp, got.accepted, got.entry_valid, got.entry_user,
                         got.entry_score, got.kept_entries, got.offers_seen);
            return;
        end
        e = due_rsp.pop_front();
        if (got.accepted !== e.accepted || got.entry_valid !== e.entry_valid ||
            got.entry_user !== e.entry_user || got.entry_score !== e.entry_score ||
            got.kept_entries !== e.kept_entries || got.offers_seen !== e.offers_seen) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch on response %0d", n_rsp);
                $display("  expected acc=%0b vld=%0b user=%h score=%0d kept=%0d offers=%0d",
                         e.accepted, e.entry_valid, e.entry_user, e.entry_score,
                         e.kept_entries, e.offers_seen);
                $display("  actual   acc=%0b vld=%0b user=%h score=%0d kept=%0d offers=%0d",
                         got.accepted, got.entry_valid, got.entry_user, got.entry_score,
                         got.kept_entries, got.offers_seen);
            end
        end
    endfunction
endclass

module tb;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASES         = 14;
    localparam int PHASE_ITEMS    = 130;
    localparam logic signed [SCORE_W-1:0] SCORE_MAX = 32'sh7FFFFFFF;
    localparam logic signed [SCORE_W-1:0] SCORE_MIN = 32'sh80000000;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    in_req_t            s_data;
    logic               m_valid;
    logic               m_ready;
    out_rsp_t           m_data;
    logic               cfg_we;
    logic [LIMIT_W-1:0] cfg_wdata;

    rank_table_board board;
    bit calm     = 1'b0;
    int hold_req = 0;
    int quiet    = 0;
    int run_left = 0;

    top_k_score_tracker_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_we)
                board.set_limit(cfg_wdata);
            if (s_valid && s_ready)
                board.note_request(s_data);
            if (m_valid && m_ready)
                board.check_response(m_data);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_we) begin
            quiet <= 0;
        end else if (quiet >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", quiet);
            $display("** top_k_score_tracker_core: FAILED **");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    function automatic int sender_gap();
        int u;
        u = $urandom_range(0, 99);
        if (u < 55)
            return 0;
        if (u < 85)
            return $urandom_range(1, 3);
        if (u < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int receiver_stall();
        int u;
        u = $urandom_range(0, 99);
        if (u < 70)
            return 1;
        if (u < 90)
            return $urandom_range(2, 4);
        if (u < 98)
            return $urandom_range(5, 15);
        return $urandom_range(20, 60);
    endfunction

    // receiver: random stalls, gapless while calm, long hold-off on request
    initial begin
        m_ready = 1'b0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (hold_req != 0) begin
                m_ready = 1'b0;
                repeat (hold_req - 1) @(negedge aclk);
                hold_req = 0;
            end else if (calm || run_left != 0) begin
                m_ready = 1'b1;
                if (run_left != 0)
                    run_left--;
            end else begin
                m_ready = 1'b0;
                repeat (receiver_stall() - 1) @(negedge aclk);
                run_left = $urandom_range(1, 24);
            end
        end
    end

    task automatic issue_request(input in_req_t r);
        int gap;
        gap = calm ? 0 : sender_gap();
        if (gap != 0) begin
            @(negedge aclk);
            s_valid = 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid = 1'b1;
        s_data  = r;
        do begin
            @(posedge aclk);
        end while (!s_ready);
    endtask

    task automatic put(input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] user,
                       input logic signed [SCORE_W-1:0] score,
                       input logic [RANK_W-1:0] rank);
        in_req_t r;
        r.kind        = kind;
        r.user_id     = user;
        r.score_value = score;
        r.rank        = rank;
        issue_request(r);
    endtask

    // hold requests until every response has arrived
    task automatic drain();
        @(negedge aclk);
        s_valid = 1'b0;
        while (board.due_rsp.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] v);
        drain();
        @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_wdata = v;
        @(negedge aclk);
        cfg_we    = 1'b0;
    endtask

    function automatic in_req_t random_request();
        in_req_t r;
        int u;
        int v;
        u = $urandom_range(0, 199);
        if (u == 0)
            r.kind = KIND_CLEAR;
        else if (u < 7)
            r.kind = KIND_IDLE;
        else if (u < 67)
            r.kind = KIND_READ;
        else
            r.kind = KIND_OFFER;
        r.user_id = $urandom;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0: r.score_value = SCORE_MAX;
                    1: r.score_value = SCORE_MIN;
                    2: r.score_value = -1;
                    default: r.score_value = 0;
                endcase
            end
            1, 2, 3, 4: begin
                v = $urandom_range(0, 16);
                r.score_value = v - 8;
            end
            default: r.score_value = $urandom;
        endcase
        // bias reads toward kept ranks
        if ($urandom_range(0, 1) == 0 && board.tab_count != 0)
            r.rank = RANK_W'($urandom_range(0, (board.tab_count > 63) ? 63 : board.tab_count));
        else
            r.rank = RANK_W'($urandom_range(0, 63));
        return r;
    endfunction

    initial begin
        logic [LIMIT_W-1:0] plan[12];
        logic [LIMIT_W-1:0] lim;
        plan      = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd7, 7'd65, 7'd16, 7'd2, 7'd100, 7'd3,
                      7'd64, 7'd40};
        board     = new();
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_we    = 1'b0;
        cfg_wdata = LIMIT_RESET;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // empty table, idle kind, score and id extremes
        put(KIND_READ, '0, 0, '0);
        put(KIND_IDLE, '1, -1, '1);
        put(KIND_OFFER, '1, SCORE_MAX, '0);
        put(KIND_OFFER, '0, SCORE_MIN, '1);
        put(KIND_READ, '0, 0, 6'd1);
        // full table: equal to smallest is refused, a tie at the top ranks later
        write_limit(7'd2);
        put(KIND_OFFER, 32'd1, SCORE_MIN, '0);
        put(KIND_OFFER, 32'd2, 5, '0);
        put(KIND_OFFER, 32'd3, SCORE_MAX, '0);
        put(KIND_READ, '0, 0, 6'd0);
        put(KIND_READ, '0, 0, 6'd1);
        put(KIND_READ, '0, 0, 6'd63);
        put(KIND_CLEAR, '1, SCORE_MAX, '1);
        put(KIND_READ, '0, 0, 6'd0);
        // zero limit acts as one
        write_limit(7'd0);
        put(KIND_OFFER, 32'd4, -1, '0);
        put(KIND_OFFER, 32'd5, -1, '0);
        put(KIND_READ, '0, 0, 6'd0);
        // oversize limit, then lower it to truncate
        write_limit(7'd127);
        put(KIND_OFFER, 32'd6, 10, '0);
        put(KIND_OFFER, 32'd7, 20, '0);
        put(KIND_OFFER, 32'd8, 10, '0);
        put(KIND_OFFER, 32'd9, 30, '0);
        write_limit(7'd3);
        put(KIND_READ, '0, 0, 6'd2);
        put(KIND_READ, '0, 0, 6'd3);
        put(KIND_OFFER, 32'd10, 10, '0);
        put(KIND_READ, '0, 0, 6'd0);

        for (int p = 0; p < PHASES; p++) begin
            lim = (p < 12) ? plan[p] : LIMIT_W'($urandom_range(0, 127));
            write_limit(lim);
            calm = (p == 3 || p == 8);
            // stall the receiver while the sender keeps sending requests
            if (p == 3)
                hold_req = 300;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 5 && n == PHASE_ITEMS / 2)
                    drain();
                issue_request(random_request());
            end
            calm = 1'b0;
        end

        drain();
        repeat (20) @(posedge aclk);
        $display("ran %0d requests and %0d responses across %0d limit settings",
                 board.n_req, board.n_rsp, board.n_limits);
        $display("offers kept %0d, offers refused by a full table %0d",
                 board.n_taken, board.n_refused);
        if (board.mismatches == 0 && board.due_rsp.size() == 0) begin
            $display("** top_k_score_tracker_core: PASSED **");
        end else begin
            $display("%0d mismatches, %0d responses missing", board.mismatches,
                     board.due_rsp.size());
            $display("** top_k_score_tracker_core: FAILED **");
        end
        $finish;
    end

endmodule
